// ===== hw/rtl/sti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sti_pkg;

  // Table and number formats.
  localparam int QUADRANT_ENTRIES = 91;
  localparam int FRACTION_BITS    = 8;
  localparam int SINE_BITS        = 16;
  localparam int ANGLE_BITS       = 18;

  localparam int QSPAN        = QUADRANT_ENTRIES - 1;
  localparam int HALF_CIRCLE  = 2 * QSPAN;
  localparam int FULL_CIRCLE  = 4 * QSPAN;
  localparam int ANGLE_LIMIT  = FULL_CIRCLE * (2 ** FRACTION_BITS);
  localparam int ADDR_BITS    = $clog2(QUADRANT_ENTRIES);
  localparam int WHOLE_BITS   = ANGLE_BITS - FRACTION_BITS;
  localparam int ROM_CNT_BITS = $clog2(QUADRANT_ENTRIES + 1);

  // Signed datapath widths: a table value, a difference, a product, a sum.
  localparam int Y_BITS    = SINE_BITS + 1;
  localparam int DIFF_BITS = SINE_BITS + 2;
  localparam int PROD_BITS = DIFF_BITS + FRACTION_BITS + 1;
  localparam int NUM_BITS  = PROD_BITS + 1;

  // Fixed-point constants used only while building the table.
  localparam int        WORK_FRAC = 28;
  localparam longint    PI_Q28    = 64'h3243F6A9;

  typedef logic [SINE_BITS-1:0] sine_rom_t [QUADRANT_ENTRIES];

  // Write request from the table loader to the memory.
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
    logic [SINE_BITS-1:0] data;
  } sti_wr_t;

  // Seventh-order Taylor sine of entry i, rounded to Q1.(SINE_BITS-1).
  function automatic logic [SINE_BITS-1:0] taylor_entry(input int i);
    longint          x;
    longint unsigned ux;
    longint unsigned p2;
    longint unsigned p3;
    longint unsigned p5;
    longint unsigned p7;
    longint          s;
    longint unsigned us;
    longint unsigned r;
    longint unsigned maxv;
    int              ob;
    int              sh;
    x    = (longint'(i) * PI_Q28 + longint'(QSPAN)) / (2 * QSPAN);
    ux   = longint'(x);
    p2   = (ux * ux) >> WORK_FRAC;
    p3   = (p2 * ux) >> WORK_FRAC;
    p5   = (p3 * p2) >> WORK_FRAC;
    p7   = (p5 * p2) >> WORK_FRAC;
    s    = x - longint'(p3 / 6) + longint'(p5 / 120) - longint'(p7 / 5040);
    ob   = SINE_BITS - 1;
    maxv = (64'd1 << ob) - 64'd1;
    if (s < 0) begin
      s = 0;
    end
    us = longint'(s);
    if (ob <= WORK_FRAC) begin
      sh = WORK_FRAC - ob;
      r  = (us + ((64'd1 << sh) >> 1)) >> sh;
    end else begin
      r = us << (ob - WORK_FRAC);
    end
    if (r > maxv) begin
      r = maxv;
    end
    return r[SINE_BITS-1:0];
  endfunction

  function automatic sine_rom_t build_rom();
    sine_rom_t t;
    for (int i = 0; i < QUADRANT_ENTRIES; i++) begin
      t[i] = taylor_entry(i);
    end
    return t;
  endfunction

  // First-quadrant sine table, one entry per degree.
  localparam sine_rom_t SINE_ROM = build_rom();

endpackage

`default_nettype wire

// ===== hw/rtl/sti_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Generic RAM: one write port, two read ports with registered read data.
module sti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 91
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sti_loader.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Copies the constant sine table into the memory after reset, one entry a cycle.
module sti_loader (
  input  wire logic            clk,
  input  wire logic            rst_n,
  output sti_pkg::sti_wr_t     wr,
  output logic                 done
);

  logic [sti_pkg::ROM_CNT_BITS-1:0] cnt_r;
  logic [sti_pkg::ROM_CNT_BITS-1:0] cnt_nxt;
  logic                             done_r;
  logic                             done_nxt;
  logic [sti_pkg::ADDR_BITS-1:0]    addr;

  assign addr = cnt_r[sti_pkg::ADDR_BITS-1:0];

  // Step through the table until the last entry has been written.
  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (!done_r) begin
      if (cnt_r == sti_pkg::ROM_CNT_BITS'(sti_pkg::QUADRANT_ENTRIES - 1)) begin
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Write request for the current entry.
  always_comb begin
    wr.we   = !done_r;
    wr.addr = addr;
    wr.data = sti_pkg::SINE_ROM[addr];
  end

  assign done = done_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sine_table_interpolator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// An accepted beat passes stage 1 (table read at both neighbor degrees at once), stage 2
// (product) and the output register. Throughput: one beat per cycle unless out_ready stalls.
// Reset: synchronous, active low; clears all valid flags and restarts the table load.
// After reset the table is copied into memory, with in_ready held low meanwhile.
module sine_table_interpolator (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [sti_pkg::ANGLE_BITS-1:0] in_angle,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed      [sti_pkg::SINE_BITS-1:0]  out_sine,
  output logic                                       out_in_range
);

  typedef struct packed {
    logic                          neg;
    logic [sti_pkg::ADDR_BITS-1:0] addr;
  } quad_t;

  // Map a whole degree onto a table entry and a sign.
  function automatic quad_t map_quad(input logic [sti_pkg::WHOLE_BITS-1:0] n);
    quad_t                          q;
    logic [sti_pkg::WHOLE_BITS-1:0] m;
    q.neg = 1'b0;
    m     = n;
    if (n > sti_pkg::WHOLE_BITS'(sti_pkg::HALF_CIRCLE)) begin
      m     = n - sti_pkg::WHOLE_BITS'(sti_pkg::HALF_CIRCLE);
      q.neg = 1'b1;
    end
    if (m <= sti_pkg::WHOLE_BITS'(sti_pkg::QSPAN)) begin
      q.addr = sti_pkg::ADDR_BITS'(m);
    end else begin
      q.addr = sti_pkg::ADDR_BITS'(sti_pkg::WHOLE_BITS'(sti_pkg::HALF_CIRCLE) - m);
    end
    return q;
  endfunction

  sti_pkg::sti_wr_t                   wr;
  logic                               load_done;
  logic                               adv_out;
  logic                               adv_s2;
  logic                               adv_s1;
  logic                               in_fire;

  logic                               range_in;
  logic [sti_pkg::WHOLE_BITS-1:0]     whole0;
  logic [sti_pkg::WHOLE_BITS-1:0]     whole1;
  quad_t                              q0;
  quad_t                              q1;
  logic [sti_pkg::SINE_BITS-1:0]      rd0;
  logic [sti_pkg::SINE_BITS-1:0]      rd1;

  logic                               s1_valid_r;
  logic                               s1_range_r;
  logic                               s1_neg0_r;
  logic                               s1_neg1_r;
  logic [sti_pkg::FRACTION_BITS-1:0]  s1_frac_r;

  logic signed [sti_pkg::Y_BITS-1:0]    y0;
  logic signed [sti_pkg::Y_BITS-1:0]    y1;
  logic signed [sti_pkg::DIFF_BITS-1:0] diff;
  logic signed [sti_pkg::PROD_BITS-1:0] s2_prod_nxt;

  logic                                 s2_valid_r;
  logic                                 s2_range_r;
  logic signed [sti_pkg::Y_BITS-1:0]    s2_y0_r;
  logic signed [sti_pkg::PROD_BITS-1:0] s2_prod_r;

  logic signed [sti_pkg::NUM_BITS-1:0]  num;
  logic signed [sti_pkg::SINE_BITS-1:0] out_sine_nxt;

  logic                                 out_valid_r;
  logic                                 out_in_range_r;
  logic signed [sti_pkg::SINE_BITS-1:0] out_sine_r;

  // Table load after reset.
  sti_loader u_loader (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .done  (load_done)
  );

  // Pipeline flow: a stage loads when it is empty or the one after it is moving.
  assign adv_out  = !out_valid_r || out_ready;
  assign adv_s2   = !s2_valid_r || adv_out;
  assign adv_s1   = !s1_valid_r || adv_s2;
  assign in_ready = adv_s1 && load_done;
  assign in_fire  = in_valid && in_ready;

  // Range check and neighbor degrees; out-of-range angles read entries zero and one.
  always_comb begin
    range_in = !in_angle[sti_pkg::ANGLE_BITS-1] &&
               (in_angle[sti_pkg::ANGLE_BITS-2:0] <
                (sti_pkg::ANGLE_BITS-1)'(sti_pkg::ANGLE_LIMIT));
    whole0   = range_in ? in_angle[sti_pkg::ANGLE_BITS-1:sti_pkg::FRACTION_BITS] : '0;
    if (whole0 == sti_pkg::WHOLE_BITS'(sti_pkg::FULL_CIRCLE - 1)) begin
      whole1 = '0;
    end else begin
      whole1 = whole0 + 1'b1;
    end
    q0 = map_quad(whole0);
    q1 = map_quad(whole1);
  end

  // The table is written only while loading, when no beat is accepted,
  // so reads that overlap a write to the same entry never feed a valid beat.
  sti_ram #(
    .WIDTH (sti_pkg::SINE_BITS),
    .DEPTH (sti_pkg::QUADRANT_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .we     (wr.we),
    .waddr  (wr.addr),
    .wdata  (wr.data),
    .re     (adv_s1),
    .raddr0 (q0.addr),
    .raddr1 (q1.addr),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // Stage 1: side information travels with the memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_s1) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s1) begin
      s1_range_r <= range_in;
      s1_neg0_r  <= q0.neg;
      s1_neg1_r  <= q1.neg;
      s1_frac_r  <= in_angle[sti_pkg::FRACTION_BITS-1:0];
    end
  end

  // Signed table values, their difference and its product with the fraction.
  always_comb begin
    y0          = s1_neg0_r ? -$signed({1'b0, rd0}) : $signed({1'b0, rd0});
    y1          = s1_neg1_r ? -$signed({1'b0, rd1}) : $signed({1'b0, rd1});
    diff        = sti_pkg::DIFF_BITS'(y1) - sti_pkg::DIFF_BITS'(y0);
    s2_prod_nxt = sti_pkg::PROD_BITS'(diff) *
                  sti_pkg::PROD_BITS'($signed({1'b0, s1_frac_r}));
  end

  // Stage 2: product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv_s2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s2) begin
      s2_range_r <= s1_range_r;
      s2_y0_r    <= y0;
      s2_prod_r  <= s2_prod_nxt;
    end
  end

  // Round to nearest, ties up: add half an LSB, then floor by the shift.
  always_comb begin
    num = (sti_pkg::NUM_BITS'(s2_y0_r) <<< sti_pkg::FRACTION_BITS)
        + sti_pkg::NUM_BITS'(s2_prod_r)
        + sti_pkg::NUM_BITS'(2 ** (sti_pkg::FRACTION_BITS - 1));
    out_sine_nxt = s2_range_r ?
                   num[sti_pkg::FRACTION_BITS +: sti_pkg::SINE_BITS] : '0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_sine_r     <= out_sine_nxt;
      out_in_range_r <= s2_range_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sine     = out_sine_r;
  assign out_in_range = out_in_range_r;

  // No beat is taken before the table is loaded.
  a_no_accept_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
    !load_done |-> !in_ready)
    else $error("input accepted during table load");

  // Pipeline contents imply a finished table.
  a_pipe_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r || s2_valid_r || out_valid_r) |-> load_done)
    else $error("pipeline busy before table load completed");

  // Once loaded, the table stays loaded.
  a_load_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    load_done |=> load_done)
    else $error("table load restarted without reset");

  // Out-of-range results carry zero.
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_in_range_r) |-> (out_sine_r == '0))
    else $error("nonzero sine for out-of-range angle");

endmodule

`default_nettype wire

// ===== bench/tb_sine_table_interpolator.sv =====
`timescale 1ns / 1ps

module tb_sine_table_interpolator;

  typedef logic signed [sti_pkg::ANGLE_BITS-1:0] angle_t;
  typedef logic signed [sti_pkg::SINE_BITS-1:0]  sine_t;

  // Angle and table geometry, in whole degrees and fraction steps.
  localparam int FRAC       = sti_pkg::FRACTION_BITS;
  localparam int ONE_DEGREE = 1 << FRAC;
  localparam int QUARTER    = sti_pkg::QUADRANT_ENTRIES - 1;
  localparam int HALF_TURN  = 2 * QUARTER;
  localparam int FULL_TURN  = 4 * QUARTER;
  localparam int TURN_STEPS = FULL_TURN * ONE_DEGREE;

  // Fixed-point constants for rebuilding the table entries.
  localparam int     WORK_FRAC = 28;
  localparam int     OUT_FRAC  = sti_pkg::SINE_BITS - 1;
  localparam longint PI_Q28    = 64'sh3243F6A9;

  localparam int RANDOM_ANGLES = 1800;
  localparam int HOLD_CYCLES   = 200;
  localparam int REPORT_LIMIT  = 10;

  // Edges of the range, quadrant seams and the wrap from 359 back to 0 degrees.
  localparam int DIRECTED_ANGLES [24] = '{
    0, 1, 128, 255, 256, 45 * 256 + 77, 89 * 256 + 255, 90 * 256, 90 * 256 + 1,
    179 * 256 + 255, 180 * 256, 180 * 256 + 128, 181 * 256 + 7, 270 * 256,
    270 * 256 + 255, 359 * 256, 359 * 256 + 128, 359 * 256 + 255, 92159, 92160,
    -1, -256, -131072, 131071
  };

  // Holds the expected sine of every accepted angle and checks the output beats.
  class sine_checker;
    typedef struct {
      angle_t angle;
      sine_t  sine;
      logic   in_range;
    } sine_expect_t;

    sine_expect_t sine_due[$];
    int           quarter_wave[sti_pkg::QUADRANT_ENTRIES];
    int           failures;

    function new();
      for (int d = 0; d < sti_pkg::QUADRANT_ENTRIES; d++) begin
        quarter_wave[d] = taylor_q15(d);
      end
      failures = 0;
    endfunction

    // Seventh-order Taylor sine of one degree step, rounded half up.
    function int taylor_q15(int deg);
      longint          x;
      longint          s;
      longint unsigned ux;
      longint unsigned p2;
      longint unsigned p3;
      longint unsigned p5;
      longint unsigned p7;
      longint unsigned us;
      longint unsigned r;
      x  = (longint'(deg) * PI_Q28 + QUARTER) / (2 * QUARTER);
      ux = x;
      p2 = (ux * ux) >> WORK_FRAC;
      p3 = (p2 * ux) >> WORK_FRAC;
      p5 = (p3 * p2) >> WORK_FRAC;
      p7 = (p5 * p2) >> WORK_FRAC;
      s  = x - longint'(p3 / 6) + longint'(p5 / 120) - longint'(p7 / 5040);
      if (s < 0) begin
        s = 0;
      end
      us = s;
      r  = (us + (64'd1 << (WORK_FRAC - OUT_FRAC - 1))) >> (WORK_FRAC - OUT_FRAC);
      if (r > (64'd1 << OUT_FRAC) - 1) begin
        r = (64'd1 << OUT_FRAC) - 1;
      end
      return int'(r);
    endfunction

    // Sine at a whole degree: mirror the second quadrant, negate the lower half.
    function int wave_at(int deg);
      int k;
      bit neg;
      neg = 1'b0;
      if (deg > HALF_TURN) begin
        deg = deg - HALF_TURN;
        neg = 1'b1;
      end
      k = (deg <= QUARTER) ? deg : HALF_TURN - deg;
      return neg ? -quarter_wave[k] : quarter_wave[k];
    endfunction

    // Linear interpolation between the whole degree and the next one.
    function sine_expect_t expected_sine(angle_t angle);
      sine_expect_t e;
      int a;
      int whole;
      int frac;
      int y0;
      int y1;
      int num;
      a = angle;
      e.angle    = angle;
      e.sine     = '0;
      e.in_range = 1'b0;
      if (a >= 0 && a < TURN_STEPS) begin
        whole = a >>> FRAC;
        frac  = a & (ONE_DEGREE - 1);
        y0    = wave_at(whole);
        y1    = wave_at((whole + 1) % FULL_TURN);
        num   = y0 * ONE_DEGREE + (y1 - y0) * frac + ONE_DEGREE / 2;
        e.sine     = sine_t'(num >>> FRAC);
        e.in_range = 1'b1;
      end
      return e;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("ERROR at %0t: %s", $time, msg);
      end
    endfunction

    function void note_angle(angle_t angle);
      sine_due.push_back(expected_sine(angle));
    endfunction

    function void check_sine(sine_t sine, logic in_range);
      sine_expect_t e;
      if (sine_due.size() == 0) begin
        flag($sformatf("output beat with no angle pending: sine %0d in_range %0b",
                       sine, in_range));
        return;
      end
      e = sine_due.pop_front();
      if (sine !== e.sine || in_range !== e.in_range) begin
        flag($sformatf("angle %0d: expected sine %0d in_range %0b, got sine %0d in_range %0b",
                       e.angle, e.sine, e.in_range, sine, in_range));
      end
    endfunction

    function int waiting();
      return sine_due.size();
    endfunction

    function void check_drained();
      if (sine_due.size() != 0) begin
        flag($sformatf("%0d results never arrived", sine_due.size()));
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  angle_t in_angle = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  sine_t  out_sine;
  logic   out_in_range;

  bit hold_req = 1'b0;
  bit out_idle_on = 1'b1;

  sine_checker chk = new();

  sine_table_interpolator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_angle     (in_angle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sine     (out_sine),
    .out_in_range (out_in_range)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_len(bit enabled);
    int r;
    if (!enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Mostly in-range angles, with exact degrees, the last degree and both out-of-range sides.
  function automatic angle_t random_angle();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 66) begin
      v = $urandom_range(0, TURN_STEPS - 1);
    end else if (r < 76) begin
      v = $urandom_range(0, FULL_TURN - 1) * ONE_DEGREE;
    end else if (r < 82) begin
      v = (FULL_TURN - 1) * ONE_DEGREE + $urandom_range(0, ONE_DEGREE - 1);
    end else if (r < 90) begin
      v = -int'($urandom_range(1, 1 << (sti_pkg::ANGLE_BITS - 1)));
    end else if (r < 96) begin
      v = $urandom_range(TURN_STEPS, (1 << (sti_pkg::ANGLE_BITS - 1)) - 1);
    end else begin
      v = $urandom;
    end
    return angle_t'(v);
  endfunction

  // Offer one angle beat and hold it until the block takes it.
  task automatic send_angle(input angle_t angle);
    in_valid <= 1'b1;
    in_angle <= angle;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    chk.note_angle(angle);
  endtask

  // Drop valid for a while, with junk on the angle port.
  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      in_angle <= angle_t'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Result side: random stalls, and a long hold-off when the sender asks for one.
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) begin
        out_idle_on = !out_idle_on;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = idle_len(out_idle_on);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Check every output beat taken by the sink.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      chk.check_sine(out_sine, out_in_range);
    end
  end

  // Reset, directed angles, random angles, then drain and report.
  initial begin : stimulus
    int  gap;
    int  burst_left;
    bit  in_idle_on;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 24; i++) begin
      send_angle(angle_t'(DIRECTED_ANGLES[i]));
      idle_input(idle_len(1'b1));
    end

    burst_left = 0;
    in_idle_on = 1'b1;
    for (int n = 0; n < RANDOM_ANGLES; n++) begin
      if (n % 50 == 0) begin
        in_idle_on = ($urandom_range(0, 3) != 0);
      end
      // Keep offering back-to-back beats while the sink holds off.
      if (n == 400 || n == 1300) begin
        hold_req = 1'b1;
        burst_left = 60;
      end
      send_angle(random_angle());
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        gap = idle_len(in_idle_on);
      end
      idle_input(gap);
    end
    in_valid <= 1'b0;

    while (chk.waiting() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    chk.check_drained();
    if (chk.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sti_pkg.sv
hw/rtl/sti_ram.sv
hw/rtl/sti_loader.sv
hw/rtl/sine_table_interpolator.sv
bench/tb_sine_table_interpolator.sv
